// ----- hw/rtl/dlps_pkg.sv -----
// Shared types and constants for the DHCP lease pool server.
// Used by dlps_lease_table and dhcp_lease_pool_server; no dependencies.
package dlps_pkg;

  localparam int POOL_ENTRIES = 16;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
  localparam int MAC_W        = 48;

  typedef logic [MAC_W-1:0] mac_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_REQUEST  = 8'd3;
  localparam logic [7:0] MSG_INFORM   = 8'd8;
  localparam logic [7:0] OPT_IP_LEN   = 8'd4;

  localparam logic [1:0] CFG_SERVER_IP  = 2'd0;
  localparam logic [1:0] CFG_POOL_START = 2'd1;
  localparam logic [1:0] CFG_POOL_SIZE  = 2'd2;

  typedef enum logic [1:0] {
    RK_NONE  = 2'd0,
    RK_OFFER = 2'd1,
    RK_ACK   = 2'd2
  } reply_kind_t;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_UNSUPPORTED = 3'd1,
    STS_POOL_FULL   = 3'd2,
    STS_BAD_OPTION  = 3'd3,
    STS_NOT_IN_POOL = 3'd4,
    STS_TAKEN       = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_CLAIM,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    mac_t data;
  } tbl_wr_t;

endpackage

// ----- hw/rtl/dlps_lease_table.sv -----
// Lease owner table: one MAC per pool entry, registered read, one write port.
// Per-entry valid bits make every entry read as free straight after reset.
// Depends on dlps_pkg.
module dlps_lease_table (
  input  logic              clk,
  input  logic              rst,
  input  dlps_pkg::idx_t    rd_addr,
  output dlps_pkg::mac_t    rd_owner,
  input  dlps_pkg::tbl_wr_t wr
);
  import dlps_pkg::*;

  mac_t                    mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] entry_vld;
  mac_t                    rd_data;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_vld[wr.addr] <= 1'b1;
      end
      rd_vld <= entry_vld[rd_addr];
    end
  end

  assign rd_owner = rd_vld ? rd_data : '0;

endmodule

// ----- hw/rtl/dhcp_lease_pool_server.sv -----
// DHCP lease pool server top level: message sequencer around the lease table.
// Depends on dlps_pkg and dlps_lease_table.
// Unsupported or malformed messages go straight to S_FINISH; discover runs the table
// scan then S_FINISH; request or inform run the scan, S_FREE, S_CLAIM and S_FINISH.
// One message at a time: in_stall stays high until the reply is loaded, which
// can wait on out_stall. Reset clears table, state, config, rd_idx and out_valid.
module dhcp_lease_pool_server (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  message_type,
  input  logic [47:0] client_mac,
  input  logic        requested_ip_found,
  input  logic [7:0]  requested_ip_length,
  input  logic [31:0] requested_ip,
  input  logic [31:0] client_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  reply_kind,
  output logic [2:0]  status,
  output logic [31:0] your_ip,
  output logic [3:0]  entry_index
);
  import dlps_pkg::*;

  state_t      state, state_next;
  logic [31:0] server_ip;
  logic [7:0]  pool_start_host;
  logic [4:0]  pool_size;

  logic [CNT_W-1:0] rd_idx;
  logic             pend;
  idx_t             cmp_idx;
  logic             is_disc;
  mac_t             mac_reg;
  logic [31:0]      target;
  logic             mac_hit, free_hit, ip_hit, ip_owned;
  idx_t             mac_idx, free_idx, ip_idx;

  reply_kind_t res_kind;
  status_t     res_status;
  logic [31:0] res_ip;
  idx_t        res_idx;

  logic [1:0]  out_kind;
  logic [2:0]  out_status;
  logic [31:0] out_ip;
  logic [3:0]  out_idx;

  idx_t    tbl_rd_addr;
  mac_t    rd_owner;
  tbl_wr_t tbl_wr;
  logic    load_out;

  logic       in_acc, type_ok, bad_opt, scan_done, claim_ok;
  logic [4:0] n_lim, n_eff;
  logic [8:0] diff;
  logic       skip_in;
  logic [8:0] cmp_host, res_host;
  logic       cmp_in_pool;
  idx_t       disc_idx;

  dlps_lease_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (tbl_rd_addr),
    .rd_owner (rd_owner),
    .wr       (tbl_wr)
  );

  // host byte of an entry, bit 8 set when it runs past 255
  function automatic logic [8:0] pool_host(input idx_t idx, input logic [7:0] start,
                                           input logic [8:0] sdiff, input logic skip);
    logic s;
    s = skip && ({5'b0, idx} >= sdiff);
    return {1'b0, start} + {5'b0, idx} + {8'b0, s};
  endfunction

  assign n_lim   = (pool_size > 5'(POOL_ENTRIES)) ? 5'(POOL_ENTRIES) : pool_size;
  assign diff    = {1'b0, server_ip[7:0]} - {1'b0, pool_start_host};
  assign skip_in = (server_ip[7:0] >= pool_start_host) && (diff < {4'b0, n_lim});
  assign n_eff   = n_lim - {4'b0, skip_in};

  assign cmp_host    = pool_host(cmp_idx, pool_start_host, diff, skip_in);
  assign cmp_in_pool = ({1'b0, cmp_idx} < n_eff) && !cmp_host[8];
  assign disc_idx    = mac_hit ? mac_idx : free_idx;
  assign res_host    = pool_host(disc_idx, pool_start_host, diff, skip_in);

  assign in_acc    = in_valid && !in_stall;
  assign type_ok   = (message_type == MSG_DISCOVER) || (message_type == MSG_REQUEST) ||
                     (message_type == MSG_INFORM);
  assign bad_opt   = (message_type == MSG_REQUEST) &&
                     (!requested_ip_found || requested_ip_length != OPT_IP_LEN);
  assign scan_done = (rd_idx == CNT_W'(POOL_ENTRIES)) && !pend;
  // an owned target freed by this same client counts as free
  assign claim_ok  = ip_hit && !(ip_owned && !(mac_hit && mac_idx == ip_idx));

  assign cfg_ready = !rst;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (!type_ok || bad_opt) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = is_disc ? S_FINISH : S_FREE;
        end
      end
      S_FREE:   state_next = S_CLAIM;
      S_CLAIM:  state_next = S_FINISH;
      S_FINISH: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = rst || (state != S_IDLE);
    tbl_rd_addr = rd_idx[IDX_W-1:0];
    tbl_wr      = '0;
    load_out    = 1'b0;
    case (state)
      S_FREE: begin
        tbl_wr.en   = mac_hit;
        tbl_wr.addr = mac_idx;
      end
      S_CLAIM: begin
        tbl_wr.en   = claim_ok;
        tbl_wr.addr = ip_idx;
        tbl_wr.data = mac_reg;
      end
      S_FINISH: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      server_ip       <= '0;
      pool_start_host <= '0;
      pool_size       <= '0;
      rd_idx          <= '0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SERVER_IP:  server_ip       <= cfg_data;
          CFG_POOL_START: pool_start_host <= cfg_data[7:0];
          CFG_POOL_SIZE:  pool_size       <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        rd_idx <= '0;
        pend   <= 1'b0;
      end else if (state == S_SCAN) begin
        pend <= (rd_idx != CNT_W'(POOL_ENTRIES));
        if (rd_idx != CNT_W'(POOL_ENTRIES)) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_disc    <= (message_type == MSG_DISCOVER);
      mac_reg    <= client_mac;
      target     <= (message_type == MSG_REQUEST) ? requested_ip : client_ip;
      mac_hit    <= 1'b0;
      free_hit   <= 1'b0;
      ip_hit     <= 1'b0;
      ip_owned   <= 1'b0;
      res_kind   <= RK_NONE;
      res_ip     <= '0;
      res_idx    <= '0;
      res_status <= !type_ok ? STS_UNSUPPORTED : (bad_opt ? STS_BAD_OPTION : STS_OK);
    end
    if (state == S_SCAN) begin
      cmp_idx <= rd_idx[IDX_W-1:0];
      if (pend && cmp_in_pool) begin
        if (!mac_hit && rd_owner == mac_reg) begin
          mac_hit <= 1'b1;
          mac_idx <= cmp_idx;
        end
        if (!free_hit && rd_owner == '0) begin
          free_hit <= 1'b1;
          free_idx <= cmp_idx;
        end
        if (!ip_hit && {server_ip[31:8], cmp_host[7:0]} == target) begin
          ip_hit   <= 1'b1;
          ip_idx   <= cmp_idx;
          ip_owned <= (rd_owner != '0);
        end
      end
      if (scan_done && is_disc) begin
        if (mac_hit || free_hit) begin
          res_kind   <= RK_OFFER;
          res_status <= STS_OK;
          res_ip     <= {server_ip[31:8], res_host[7:0]};
          res_idx    <= disc_idx;
        end else begin
          res_status <= STS_POOL_FULL;
        end
      end
    end
    if (state == S_CLAIM) begin
      if (!ip_hit) begin
        res_status <= STS_NOT_IN_POOL;
      end else if (!claim_ok) begin
        res_status <= STS_TAKEN;
      end else begin
        res_kind   <= RK_ACK;
        res_status <= STS_OK;
        res_ip     <= target;
        res_idx    <= ip_idx;
      end
    end
    if (load_out) begin
      out_kind   <= res_kind;
      out_status <= res_status;
      out_ip     <= res_ip;
      out_idx    <= 4'(res_idx);
    end
  end

  assign reply_kind  = out_kind;
  assign status      = out_status;
  assign your_ip     = out_ip;
  assign entry_index = out_idx;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted transaction did not start work");

  a_finish_fills_output: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && !out_valid |=> out_valid)
    else $error("finished result not presented");

  a_claim_write_acks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLAIM && tbl_wr.en |=> res_kind == RK_ACK && res_status == STS_OK)
    else $error("table claim without acknowledge");

  a_no_reply_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_kind == RK_NONE |-> your_ip == '0 && entry_index == '0)
    else $error("no-reply transaction carries address data");

endmodule
